// File: src/hpm_pkg.sv
`timescale 1ns / 1ps
// Shared types, header constants and helpers for the header payload muter.
package hpm_pkg;

	localparam int unsigned HDR_LEN = 5;

	typedef enum logic [1:0] {
		PH_SEARCH  = 2'd0,
		PH_MATCH   = 2'd1,
		PH_LEN     = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       tap_valid;
		logic [7:0] tap_byte;
	} hpm_result_t;

	// Header byte at a given position; positions past the header give zero.
	function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0: b = 8'h71;
			3'd1: b = 8'hFE;
			3'd2: b = 8'h39;
			3'd3: b = 8'h1D;
			3'd4: b = 8'h07;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: src/hpm_in_if.sv
`timescale 1ns / 1ps
// Input byte channel: valid/ready handshake carrying one raw byte per beat.
interface hpm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

// File: src/hpm_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying the passed-on byte and tap copy.
interface hpm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       tap_valid;
	logic [7:0] tap_byte;

	modport source(output valid, output out_byte, output tap_valid, output tap_byte,
		input ready);
	modport sink(input valid, input out_byte, input tap_valid, input tap_byte,
		output ready);
endinterface

// File: src/hpm_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake carrying the mute enable.
interface hpm_cfg_if;
	logic valid;
	logic ready;
	logic mute_enable;

	modport source(output valid, output mute_enable, input ready);
	modport sink(input valid, input mute_enable, output ready);
endinterface

// File: src/header_payload_muter.sv
`timescale 1ns / 1ps
// Path: an accepted beat waits in the input register, is parsed as it moves on
//   into the result register, and its result is offered from there.
// Throughput: one byte per cycle while dout.ready holds; a stalled output holds the pipe.
// Reset (arst_n low, asynchronous): parser searches for a header, XOR and counters
//   clear, muting is off, both pipeline registers empty.
// Top level of the header payload muter.
module header_payload_muter
	import hpm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	hpm_in_if.sink    din,
	hpm_out_if.source dout,
	hpm_cfg_if.sink   cfg
);

	// input register
	logic        vld_s1;
	logic [7:0]  byte_s1;

	// result register
	logic        vld_s2;
	hpm_result_t res_s2;

	logic        mute_q;
	logic        advance;
	hpm_result_t res_comb;

	// The byte in the input register moves on whenever the result register is
	// free or being emptied this cycle; the input side then refills at once.
	assign advance   = vld_s1 && (!vld_s2 || dout.ready);
	assign din.ready = !vld_s1 || advance;

	// configuration is always taken
	assign cfg.ready = 1'b1;

	hpm_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_in (byte_s1),
		.mute    (mute_q),
		.res     (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q <= 1'b0;
		end else if (cfg.valid) begin
			mute_q <= cfg.mute_enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (din.ready)
				vld_s1 <= din.valid;
			if (advance)
				vld_s2 <= 1'b1;
			else if (dout.ready)
				vld_s2 <= 1'b0;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (din.ready && din.valid)
			byte_s1 <= din.in_byte;
		if (advance)
			res_s2 <= res_comb;
	end

	assign dout.valid     = vld_s2;
	assign dout.out_byte  = res_s2.out_byte;
	assign dout.tap_valid = res_s2.tap_valid;
	assign dout.tap_byte  = res_s2.tap_byte;

endmodule

// File: src/hpm_parser.sv
`timescale 1ns / 1ps
// Frame parser: header search, length capture, payload muting and XOR patching.
module hpm_parser
	import hpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_in,
	input  logic        mute,
	output hpm_result_t res
);

	phase_t     phase_q, phase_n;
	logic [2:0] idx_q, idx_n;
	logic [7:0] left_q, left_n;
	logic [7:0] xor_q, xor_n;
	logic       patch_q, patch_n;

	logic [7:0] b;
	logic [7:0] left_dec;
	logic [7:0] xor_run;
	logic [2:0] idx_inc;
	logic       hdr_hit;
	logic       start_hit;

	// a pending patch replaces the arriving byte before parsing
	assign b         = patch_q ? xor_q : byte_in;
	assign left_dec  = left_q - 8'd1;
	assign xor_run   = xor_q ^ b;
	assign idx_inc   = idx_q + 3'd1;
	assign hdr_hit   = (idx_q < 3'(HDR_LEN)) && (hdr_byte(idx_q) == b);
	assign start_hit = (b == hdr_byte(3'd0));

	// next state
	always_comb begin
		phase_n = phase_q;
		idx_n   = idx_q;
		left_n  = left_q;
		xor_n   = (phase_q != PH_PAYLOAD) ? xor_run : xor_q;
		patch_n = 1'b0;
		unique case (phase_q)
			PH_SEARCH, PH_MATCH: begin
				if (phase_q == PH_MATCH && hdr_hit) begin
					idx_n = idx_inc;
					if (idx_inc >= 3'(HDR_LEN))
						phase_n = PH_LEN;
				end else if (start_hit) begin
					xor_n   = b;
					idx_n   = 3'd1;
					phase_n = PH_MATCH;
				end else begin
					phase_n = PH_SEARCH;
				end
			end
			PH_LEN: begin
				left_n  = b;
				phase_n = (b != 8'd0) ? PH_PAYLOAD : PH_SEARCH;
			end
			PH_PAYLOAD: begin
				left_n = left_dec;
				if (left_dec == 8'd0) begin
					phase_n = PH_SEARCH;
					patch_n = mute;
				end
			end
			default: phase_n = PH_SEARCH;
		endcase
	end

	// outputs
	always_comb begin
		res.out_byte  = b;
		res.tap_valid = 1'b0;
		res.tap_byte  = 8'd0;
		if (phase_q == PH_PAYLOAD) begin
			res.tap_valid = 1'b1;
			res.tap_byte  = b;
			if (mute)
				res.out_byte = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			idx_q   <= 3'd0;
			left_q  <= 8'd0;
			xor_q   <= 8'd0;
			patch_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			left_q  <= left_n;
			xor_q   <= xor_n;
			patch_q <= patch_n;
		end
	end

endmodule

// File: src/hpm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the header payload muter, bound to the top level.
module hpm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       tap_valid,
	input logic [7:0] tap_byte
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(tap_byte)
			&& $stable(tap_valid))
		else $error("stalled result beat changed");

	// tap copy is zero outside payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tap_valid |-> tap_byte == 8'd0)
		else $error("tap byte set outside payload");

	// a payload byte is passed through or muted to zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tap_valid && out_byte != tap_byte |-> out_byte == 8'd0)
		else $error("payload byte altered other than by muting");

	// a result beat rises only for an accepted input beat that has passed both registers
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result beat without input beat");

endmodule

bind header_payload_muter hpm_checker u_hpm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_byte  (dout.out_byte),
	.tap_valid (dout.tap_valid),
	.tap_byte  (dout.tap_byte)
);

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the header payload muter: byte stream, scoreboard and config.
module tb;
	import hpm_pkg::*;

	// Sync word the parser hunts for, first byte in the top octet.
	localparam logic [39:0] SYNC_WORD = 40'h71FE391D07;
	// XOR of the five sync bytes. Patch value = this ^ length, so a length of this ^
	// the first sync byte makes the patched byte a fresh sync start.
	localparam logic [7:0]  SYNC_XOR  = 8'hAC;
	localparam int          PHASE_LEN = 150;

	function automatic logic [7:0] sync_at(input int pos);
		return SYNC_WORD[39 - 8 * pos -: 8];
	endfunction

	// Scoreboard: tracks the parser state, queues the expected output beat for every
	// accepted input beat and compares output beats in order.
	class frame_scoreboard;
		phase_t      ph;
		logic [2:0]  sync_pos;
		logic [7:0]  bytes_left;
		logic [7:0]  run_xor;
		bit          patch_due;
		bit          mute;
		hpm_result_t due_results[$];
		int          errors;
		int          n_in;
		int          n_checked;
		int          n_tapped;
		int          n_patched;
		int          n_cfg;

		function new();
			ph         = PH_SEARCH;
			sync_pos   = 3'd0;
			bytes_left = 8'd0;
			run_xor    = 8'd0;
			patch_due  = 1'b0;
			mute       = 1'b0;
		endfunction

		function void set_mute(input logic v);
			mute = v;
			n_cfg++;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// Only the first sync byte may (re)start a header.
		function void restart(input logic [7:0] b);
			if (b == sync_at(0)) begin
				run_xor  = b;
				sync_pos = 3'd1;
				ph       = PH_MATCH;
			end else begin
				ph = PH_SEARCH;
			end
		endfunction

		function void note_byte(input logic [7:0] raw);
			logic [7:0]  b;
			hpm_result_t r;
			b = raw;
			n_in++;
			// patched byte replaces the arriving one, and is parsed as such
			if (patch_due) begin
				b         = run_xor;
				patch_due = 1'b0;
				n_patched++;
			end
			r.out_byte  = b;
			r.tap_valid = 1'b0;
			r.tap_byte  = 8'd0;
			if (ph != PH_PAYLOAD)
				run_xor = run_xor ^ b;
			case (ph)
				PH_MATCH: begin
					if (sync_pos < HDR_LEN && b == sync_at(int'(sync_pos))) begin
						sync_pos = sync_pos + 3'd1;
						if (sync_pos >= HDR_LEN)
							ph = PH_LEN;
					end else begin
						restart(b);
					end
				end
				PH_SEARCH: restart(b);
				PH_LEN: begin
					bytes_left = b;
					ph = (b != 8'd0) ? PH_PAYLOAD : PH_SEARCH;
				end
				default: begin
					r.tap_valid = 1'b1;
					r.tap_byte  = b;
					n_tapped++;
					if (mute)
						r.out_byte = 8'd0;
					bytes_left = bytes_left - 8'd1;
					if (bytes_left == 8'd0) begin
						ph = PH_SEARCH;
						// enable as seen on the last payload byte decides the patch
						if (mute)
							patch_due = 1'b1;
					end
				end
			endcase
			due_results.push_back(r);
		endfunction

		function void check_result(input hpm_result_t got);
			hpm_result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: output beat %02h/%0b/%02h with nothing expected", $time,
					got.out_byte, got.tap_valid, got.tap_byte);
				errors++;
				return;
			end
			want = due_results.pop_front();
			n_checked++;
			if (got.out_byte !== want.out_byte) begin
				$display("%0t: out_byte expected %02h got %02h", $time,
					want.out_byte, got.out_byte);
				errors++;
			end
			if (got.tap_valid !== want.tap_valid) begin
				$display("%0t: tap_valid expected %0b got %0b", $time,
					want.tap_valid, got.tap_valid);
				errors++;
			end
			if (got.tap_byte !== want.tap_byte) begin
				$display("%0t: tap_byte expected %02h got %02h", $time,
					want.tap_byte, got.tap_byte);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	hpm_in_if  din();
	hpm_out_if dout();
	hpm_cfg_if cfg();

	header_payload_muter u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din),
		.dout  (dout),
		.cfg   (cfg)
	);

	frame_scoreboard sb = new();

	// Idling knobs: while set, the relevant side never idles.
	bit tx_calm;
	bit rx_calm;
	int n_sent;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("header_payload_muter regression: fail");
		$finish;
	end

	// Mostly back-to-back, some short gaps, the odd long one.
	function automatic int gap_len(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Sink side: random back-pressure on the output channel.
	initial begin
		int stall_left;
		stall_left = 0;
		dout.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				dout.ready <= 1'b0;
			end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
				stall_left = gap_len(1'b0);
				dout.ready <= 1'b0;
			end else begin
				dout.ready <= 1'b1;
			end
		end
	end

	// Monitor: sample all three channels at the edge; inputs noted before outputs.
	always @(posedge clk) begin
		hpm_result_t got;
		if (arst_n) begin
			if (din.valid && din.ready)
				sb.note_byte(din.in_byte);
			if (cfg.valid && cfg.ready)
				sb.set_mute(cfg.mute_enable);
			if (dout.valid && dout.ready) begin
				got.out_byte  = dout.out_byte;
				got.tap_valid = dout.tap_valid;
				got.tap_byte  = dout.tap_byte;
				sb.check_result(got);
			end
		end
	end

	// One input beat: optional gap, then hold valid until accepted. Valid is left
	// high afterwards so back-to-back beats never drop it.
	task automatic send_byte(input logic [7:0] b);
		int g;
		g = gap_len(tx_calm);
		if (g > 0) begin
			din.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		din.valid   <= 1'b1;
		din.in_byte <= b;
		do @(posedge clk); while (!din.ready);
		n_sent++;
	endtask

	task automatic drain();
		din.valid <= 1'b0;
		// one edge first, so a beat taken at the current edge is already noted
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Register write only with the pipe empty.
	task automatic write_mute(input logic v);
		drain();
		cfg.valid       <= 1'b1;
		cfg.mute_enable <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// Payload bytes lean towards sync bytes to show they are not parsed inside a frame.
	function automatic logic [7:0] payload_byte();
		if ($urandom_range(0, 3) == 0)
			return sync_at($urandom_range(0, HDR_LEN - 1));
		return 8'($urandom);
	endfunction

	task automatic send_frame(input logic [7:0] len);
		for (int i = 0; i < HDR_LEN; i++)
			send_byte(sync_at(i));
		send_byte(len);
		for (int i = 0; i < len; i++)
			send_byte(payload_byte());
	endtask

	// Sync prefix cut short by a wrong byte, sometimes a fresh first sync byte.
	task automatic send_broken_sync();
		int         n;
		logic [7:0] b;
		n = $urandom_range(1, HDR_LEN - 1);
		for (int i = 0; i < n; i++)
			send_byte(sync_at(i));
		b = ($urandom_range(0, 2) == 0) ? sync_at(0) : 8'($urandom);
		if (b == sync_at(n))
			b = ~b;
		send_byte(b);
	endtask

	// Frame lengths: mostly short, some zero, rarely long or special patch values.
	function automatic logic [7:0] frame_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 8'($urandom_range(1, 8));
		if (r < 85)
			return 8'($urandom_range(9, 40));
		if (r < 97)
			return 8'd0;
		case ($urandom_range(0, 2))
			0: return SYNC_XOR ^ sync_at(0);
			1: return SYNC_XOR;
			default: return 8'hFF;
		endcase
	endfunction

	task automatic send_group();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			send_frame(frame_len());
		end else if (r < 75) begin
			send_broken_sync();
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) send_byte(8'($urandom));
		end
	endtask

	initial begin
		int phase_end;
		arst_n          = 1'b0;
		tx_calm         = 1'b0;
		rx_calm         = 1'b0;
		n_sent          = 0;
		din.valid       <= 1'b0;
		din.in_byte     <= 8'd0;
		cfg.valid       <= 1'b0;
		cfg.mute_enable <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: plain two-byte frame, then two noise beats with extreme values.
		write_mute(1'b0);
		send_frame(8'd2);
		drain();
		send_byte(8'h00);
		send_byte(8'hFF);
		// Muted one-byte frame; enable dropped before the following beat, which must
		// still be replaced by the XOR.
		write_mute(1'b1);
		send_frame(8'd1);
		write_mute(1'b0);
		send_byte(8'h80);
		// Restart on a first sync byte mid-header, then a zero length.
		send_byte(sync_at(0));
		send_byte(sync_at(1));
		send_frame(8'd0);

		// Random phases, alternating the mute enable; some with one side never idling.
		for (int p = 0; p < 6; p++) begin
			write_mute((p == 5) ? 1'($urandom) : ((p % 2) == 0));
			tx_calm   = (p == 2);
			rx_calm   = (p == 3);
			phase_end = n_sent + PHASE_LEN;
			// patched byte that is itself a sync start, parsed as one
			if (p == 0)
				send_frame(SYNC_XOR ^ sync_at(0));
			while (n_sent < phase_end)
				send_group();
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;

		drain();
		repeat (8) @(posedge clk);

		$display("%0d input beats, %0d output beats checked, %0d mute writes",
			sb.n_in, sb.n_checked, sb.n_cfg);
		$display("%0d payload bytes tapped, %0d bytes replaced by the frame XOR",
			sb.n_tapped, sb.n_patched);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("header_payload_muter regression: pass");
		end else begin
			$display("header_payload_muter regression: fail");
		end
		$finish;
	end

endmodule

// File: files.f
src/hpm_pkg.sv
src/hpm_in_if.sv
src/hpm_out_if.sv
src/hpm_cfg_if.sv
src/hpm_parser.sv
src/header_payload_muter.sv
src/hpm_checker.sv
test/tb.sv
